// ===== sv/plb_pkg.sv =====
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the price ladder best-level tracker.
// ----------------------------------------------------------------------------
package plb_pkg;

  // Default sizing of the ladder.
  localparam int unsigned LADDER_LEVELS_DEF = 8192;
  localparam int unsigned COUNT_BITS_DEF    = 16;

  // Fixed field widths.
  localparam int unsigned QTY_BITS     = 48;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_PRICE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOOK_SIDE  = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Request codes.
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_REM = 1'b1;

  // Book side codes.
  localparam logic SIDE_BID = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [31:0] price;
    logic [31:0] qty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                best_valid;
    logic [31:0]         top_price;
    logic [QTY_BITS-1:0] best_qty;
    logic [QTY_BITS-1:0] level_qty;
    logic [15:0]         level_orders;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic srch;
    logic scan;
    logic rdq;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic need_search;
    logic word_hit;
    logic sum_hit;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/price_ladder_best_tracker_top.sv =====
// ----------------------------------------------------------------------------
// price_ladder_best_tracker_top
// One side of an order book price ladder with best-level tracking.
// ----------------------------------------------------------------------------
// After reset the block sweeps its level store, one level per cycle, through
// all LADDER_LEVELS levels (8192 by default) and stalls its input meanwhile;
// configuration writes are taken at any time. An item is then accepted while
// the level store is read, its level is updated and its result registered;
// no new item is taken before that result is registered. A remove that
// empties the best level adds a search through the occupancy bitmap: a search
// step alone when the book becomes empty, a search and a quantity read when
// the next level lies in the same bitmap word (64 levels by default), and a
// search, a word scan and a quantity read when the word summary must be
// consulted. The single read port of the level store puts these steps in
// sequence. A result still waiting at the output holds the following item in
// its final step; the input stalls until the waiting result is taken.
module price_ladder_best_tracker_top #(
  parameter int unsigned LADDER_LEVELS = plb_pkg::LADDER_LEVELS_DEF,
  parameter int unsigned COUNT_BITS    = plb_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  plb_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output plb_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [plb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  import plb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration registers are always writable.
  assign cfg_ready = 1'b1;

  // Controller.
  plb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  plb_dp #(
    .LADDER_LEVELS (LADDER_LEVELS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sv/plb_ram.sv =====
// ----------------------------------------------------------------------------
// plb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module plb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/plb_ctrl.sv =====
// ----------------------------------------------------------------------------
// plb_ctrl
// Sequencing state machine: clearing pass, level update, best-level search.
// ----------------------------------------------------------------------------
module plb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  plb_pkg::sts_t sts,
  output plb_pkg::cmd_t cmd
);

  import plb_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_SRCH  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_RDQ   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.update = 1'b1;
        state_nxt  = sts.need_search ? S_SRCH : S_FIN;
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        priority if (sts.word_hit) begin
          state_nxt = S_RDQ;
        end else if (sts.sum_hit) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_RDQ;
      end
      S_RDQ: begin
        cmd.rdq   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/plb_dp.sv =====
// ----------------------------------------------------------------------------
// plb_dp
// Datapath: configuration, level store, occupancy bitmap, best-level state
// and the result register.
// ----------------------------------------------------------------------------
module plb_dp #(
  parameter int unsigned LADDER_LEVELS = plb_pkg::LADDER_LEVELS_DEF,
  parameter int unsigned COUNT_BITS    = plb_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  plb_pkg::in_item_t                    in_data,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output plb_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  input  logic [plb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [31:0]                          cfg_data,
  input  plb_pkg::cmd_t                        cmd,
  output plb_pkg::sts_t                        sts
);

  import plb_pkg::*;

  localparam int unsigned IB  = $clog2(LADDER_LEVELS);
  localparam int unsigned WB  = (LADDER_LEVELS >= 128) ? 64 : LADDER_LEVELS / 2;
  localparam int unsigned WBB = $clog2(WB);
  localparam int unsigned NW  = LADDER_LEVELS / WB;
  localparam int unsigned WIB = $clog2(NW);
  localparam int unsigned LW  = COUNT_BITS + QTY_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [QTY_BITS-1:0]   QTY_MAX = {QTY_BITS{1'b1}};

  // Configuration registers.
  logic [31:0] base_r;
  logic        side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      side_r <= SIDE_BID;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BASE_PRICE) begin
        base_r <= cfg_data;
      end else if (cfg_index == CFG_BOOK_SIDE) begin
        side_r <= cfg_data[0];
      end
    end
  end

  // Item registers and best-level state.
  logic                  req_r, oor_r;
  logic [31:0]           qty_r;
  logic [IB-1:0]         idx_r;
  logic [IB-1:0]         best_idx_r;
  logic                  best_pres_r;
  logic [QTY_BITS-1:0]   best_qty_r;
  logic [NW-1:0]         sum_r;
  logic [WB-1:0]         bmw_r;
  logic [1:0]            status_r;
  logic [QTY_BITS-1:0]   lq_r;
  logic [COUNT_BITS-1:0] lo_r;
  logic [WIB-1:0]        sword_r;
  logic [IB-1:0]         clr_r;
  out_item_t             out_r;
  logic                  out_valid_r;

  // Memory ports.
  logic            lvl_we, bm_we;
  logic [IB-1:0]   lvl_wa, lvl_ra;
  logic [LW-1:0]   lvl_wd, lvl_rd;
  logic [WIB-1:0]  bm_wa, bm_ra;
  logic [WB-1:0]   bm_wd, bm_rd;

  plb_ram #(.WIDTH(LW), .DEPTH(LADDER_LEVELS)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
    .raddr(lvl_ra), .rdata(lvl_rd)
  );

  plb_ram #(.WIDTH(WB), .DEPTH(NW)) u_bm (
    .clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd),
    .raddr(bm_ra), .rdata(bm_rd)
  );

  // Range check of the incoming price.
  logic [31:0]   diff;
  logic          in_oor;
  logic [IB-1:0] idx_in;

  assign diff   = in_data.price - base_r;
  assign in_oor = (in_data.price < base_r) || (diff >= 32'(LADDER_LEVELS));
  assign idx_in = diff[IB-1:0];

  // Level update arithmetic.
  logic [COUNT_BITS-1:0] cnt, new_cnt;
  logic [QTY_BITS-1:0]   tq, new_tq;
  logic [QTY_BITS:0]     sum;
  logic                  wr_ok, under, emptied, filled;
  logic [1:0]            new_status;
  logic [WB-1:0]         new_bmw;
  logic [WBB-1:0]        bpos;
  logic [WIB-1:0]        widx;
  logic                  better;

  assign cnt  = lvl_rd[LW-1:QTY_BITS];
  assign tq   = lvl_rd[QTY_BITS-1:0];
  assign sum  = {1'b0, tq} + (QTY_BITS + 1)'(qty_r);
  assign bpos = idx_r[WBB-1:0];
  assign widx = idx_r[IB-1:WBB];

  always_comb begin
    new_cnt    = cnt;
    new_tq     = tq;
    wr_ok      = 1'b0;
    under      = QTY_BITS'(qty_r) > tq;
    emptied    = 1'b0;
    filled     = 1'b0;
    new_status = ST_OK;
    new_bmw    = bm_rd;
    if (req_r == REQ_ADD) begin
      if (cnt == CNT_MAX) begin
        new_status = ST_FULL;
      end else begin
        wr_ok   = 1'b1;
        filled  = (cnt == '0);
        new_cnt = cnt + 1'b1;
        new_tq  = sum[QTY_BITS] ? QTY_MAX : sum[QTY_BITS-1:0];
      end
    end else begin
      if (cnt == '0) begin
        new_status = ST_EMPTY;
      end else begin
        wr_ok      = 1'b1;
        new_cnt    = cnt - 1'b1;
        new_tq     = under ? '0 : tq - QTY_BITS'(qty_r);
        new_status = under ? ST_EMPTY : ST_OK;
        if (new_cnt == '0) begin
          emptied = 1'b1;
          new_tq  = '0;
        end
      end
    end
    if (filled) begin
      new_bmw[bpos] = 1'b1;
    end
    if (emptied) begin
      new_bmw[bpos] = 1'b0;
    end
  end

  assign better = (side_r == SIDE_BID) ? (idx_r > best_idx_r) : (idx_r < best_idx_r);

  // Search inside the emptied level's own word, in the worse direction.
  logic [WB-1:0]  wmask;
  logic [WBB-1:0] wpos;
  logic           whit;

  always_comb begin
    wpos = '0;
    for (int i = 0; i < WB; i++) begin
      wmask[i] = (side_r == SIDE_BID) ? (WBB'(i) < bpos) : (WBB'(i) > bpos);
    end
    whit = |(bmw_r & wmask);
    if (side_r == SIDE_BID) begin
      for (int i = 0; i < WB; i++) begin
        if (bmw_r[i] && wmask[i]) wpos = WBB'(i);
      end
    end else begin
      for (int i = WB - 1; i >= 0; i--) begin
        if (bmw_r[i] && wmask[i]) wpos = WBB'(i);
      end
    end
  end

  // Search of the word summary for the nearest occupied word.
  logic [NW-1:0]  smask;
  logic [WIB-1:0] spos;
  logic           shit;

  always_comb begin
    spos = '0;
    for (int i = 0; i < NW; i++) begin
      smask[i] = (side_r == SIDE_BID) ? (WIB'(i) < widx) : (WIB'(i) > widx);
    end
    shit = |(sum_r & smask);
    if (side_r == SIDE_BID) begin
      for (int i = 0; i < NW; i++) begin
        if (sum_r[i] && smask[i]) spos = WIB'(i);
      end
    end else begin
      for (int i = NW - 1; i >= 0; i--) begin
        if (sum_r[i] && smask[i]) spos = WIB'(i);
      end
    end
  end

  // Best bit inside a word fetched from the bitmap.
  logic [WBB-1:0] fpos;

  always_comb begin
    fpos = '0;
    if (side_r == SIDE_BID) begin
      for (int i = 0; i < WB; i++) begin
        if (bm_rd[i]) fpos = WBB'(i);
      end
    end else begin
      for (int i = WB - 1; i >= 0; i--) begin
        if (bm_rd[i]) fpos = WBB'(i);
      end
    end
  end

  // Memory port selection.
  always_comb begin
    lvl_we = 1'b0;
    lvl_wa = idx_r;
    lvl_wd = {new_cnt, new_tq};
    lvl_ra = idx_in;
    bm_we  = 1'b0;
    bm_wa  = widx;
    bm_wd  = new_bmw;
    bm_ra  = idx_in[IB-1:WBB];
    if (cmd.clear) begin
      lvl_we = 1'b1;
      lvl_wa = clr_r;
      lvl_wd = '0;
      bm_we  = 1'b1;
      bm_wa  = clr_r[WIB-1:0];
      bm_wd  = '0;
    end else if (cmd.update) begin
      lvl_we = !oor_r && wr_ok;
      bm_we  = !oor_r;
    end
    if (cmd.srch) begin
      lvl_ra = {widx, wpos};
      bm_ra  = spos;
    end else if (cmd.scan) begin
      lvl_ra = {sword_r, fpos};
    end
  end

  // Status towards the controller.
  assign sts.clr_last    = (clr_r == {IB{1'b1}});
  assign sts.need_search = !oor_r && emptied && best_pres_r && (idx_r == best_idx_r);
  assign sts.word_hit    = whit;
  assign sts.sum_hit     = shit;
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Best-level state and word summary.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_idx_r  <= '0;
      best_pres_r <= 1'b0;
      best_qty_r  <= '0;
      sum_r       <= '0;
    end else begin
      if (cmd.update && !oor_r) begin
        sum_r[widx] <= |new_bmw;
        if (wr_ok && (req_r == REQ_ADD)) begin
          if (!best_pres_r || better) begin
            best_pres_r <= 1'b1;
            best_idx_r  <= idx_r;
            best_qty_r  <= new_tq;
          end else if (idx_r == best_idx_r) begin
            best_qty_r <= new_tq;
          end
        end else if (wr_ok && best_pres_r && (idx_r == best_idx_r) && !emptied) begin
          best_qty_r <= new_tq;
        end
      end
      if (cmd.srch) begin
        priority if (whit) begin
          best_idx_r <= {widx, wpos};
        end else if (!shit) begin
          best_pres_r <= 1'b0;
          best_idx_r  <= '0;
          best_qty_r  <= '0;
        end
      end
      if (cmd.scan) begin
        best_idx_r <= {sword_r, fpos};
      end
      if (cmd.rdq) begin
        best_qty_r <= lvl_rd[QTY_BITS-1:0];
      end
    end
  end

  // Item payload and per-item results.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data.req_type;
      qty_r <= in_data.qty;
      idx_r <= idx_in;
      oor_r <= in_oor;
    end
    if (cmd.update) begin
      bmw_r <= new_bmw;
      if (oor_r) begin
        status_r <= ST_RANGE;
        lq_r     <= '0;
        lo_r     <= '0;
      end else begin
        status_r <= new_status;
        lq_r     <= new_tq;
        lo_r     <= new_cnt;
      end
    end
    if (cmd.srch) begin
      sword_r <= spos;
    end
  end

  // Result register.
  logic [31:0] lo_ext;
  assign lo_ext = 32'(lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.status       <= status_r;
      out_r.best_valid   <= best_pres_r;
      out_r.top_price    <= best_pres_r ? base_r + 32'(best_idx_r) : '0;
      out_r.best_qty     <= best_pres_r ? best_qty_r : '0;
      out_r.level_qty    <= lq_r;
      out_r.level_orders <= lo_ext[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
